FILE: sv/despeckle_hole_fill_filter_assert.svh
// ----------------------------------------------------------------------------
// Despeckle filter assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DESPECKLE_HOLE_FILL_FILTER_ASSERT_SVH
`define DESPECKLE_HOLE_FILL_FILTER_ASSERT_SVH

// same-cycle implication
`define DHF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DHF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dhf_pkg.sv
// ----------------------------------------------------------------------------
// Despeckle filter package
// Sizes, register indexes, command codes, FSM states and shared structs.
// ----------------------------------------------------------------------------
package dhf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HCNT_W = ROW_W + 1;

  localparam int LEVEL_W      = 4;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int MAX_LEVEL    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int SUM_W   = 11;
  localparam int CNT_W   = 4;
  localparam int BANK_W  = 2;
  localparam int NBANK   = 3;
  localparam int RAM_DEPTH = NBANK * MAX_WIDTH;
  localparam int RAM_AW  = $clog2(RAM_DEPTH);

  localparam int SLOT_W    = 4;
  localparam int NBR_SLOTS = 9;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SELF_RD,
    ST_SELF_CHK,
    ST_NBR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WR_RES,
    ST_WR_IN,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic                       start;
    logic [CNT_W-1:0]           divisor;
    logic [2:0][SUM_W-1:0]      dividend;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic [2:0][CH_W-1:0]       quotient;
  } div_rsp_t;

  function automatic logic [RAM_AW-1:0] ram_addr(input logic [BANK_W-1:0] bank,
                                                 input logic [COL_W-1:0] col);
    ram_addr = RAM_AW'(RAM_AW'(bank) * RAM_AW'(MAX_WIDTH)) + RAM_AW'(col);
  endfunction

  function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] bank);
    bank_inc = (bank == BANK_W'(NBANK - 1)) ? '0 : bank + 1'b1;
  endfunction

  function automatic logic [BANK_W-1:0] bank_dec(input logic [BANK_W-1:0] bank);
    bank_dec = (bank == '0) ? BANK_W'(NBANK - 1) : bank - 1'b1;
  endfunction

endpackage

FILE: sv/dhf_if.sv
// ----------------------------------------------------------------------------
// Despeckle filter channel interfaces
// Pixel input, filtered output and register write channels.
// ----------------------------------------------------------------------------
interface dhf_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [dhf_pkg::CH_W-1:0] pixel_red;
  logic [dhf_pkg::CH_W-1:0] pixel_green;
  logic [dhf_pkg::CH_W-1:0] pixel_blue;

  modport source(output valid, cmd, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink(input valid, cmd, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface dhf_res_if;
  logic                     valid;
  logic                     ready;
  logic [dhf_pkg::CH_W-1:0] out_red;
  logic [dhf_pkg::CH_W-1:0] out_green;
  logic [dhf_pkg::CH_W-1:0] out_blue;
  logic                     frame_end;

  modport source(output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink(input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface dhf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dhf_pkg::CFG_IDX_W-1:0]  index;
  logic [dhf_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/dhf_line_ram.sv
// ----------------------------------------------------------------------------
// Despeckle filter line RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dhf_line_ram #(
  parameter int DEPTH  = 768,
  parameter int DATA_W = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dhf_div_unit.sv
// ----------------------------------------------------------------------------
// Despeckle filter divide unit
// Restoring divider, one quotient bit per cycle for all three channels.
// ----------------------------------------------------------------------------
`include "despeckle_hole_fill_filter_assert.svh"

module dhf_div_unit (
  input  logic              clk,
  input  logic              rst,
  input  dhf_pkg::div_req_t req,
  output dhf_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(dhf_pkg::SUM_W + 1);

  logic                                  busy;
  logic                                  done;
  logic [STEP_W-1:0]                     step_cnt;
  logic [dhf_pkg::CNT_W-1:0]             dvs;
  logic [2:0][dhf_pkg::SUM_W-1:0]        dvd;
  logic [2:0][dhf_pkg::SUM_W-1:0]        quo;
  logic [2:0][dhf_pkg::CNT_W-1:0]        rem;
  logic [2:0][dhf_pkg::CNT_W-1:0]        rem_next;
  logic [2:0]                            qbit;

  always_comb begin
    logic [dhf_pkg::CNT_W:0] trial;
    for (int ch = 0; ch < 3; ch++) begin
      trial = {rem[ch], dvd[ch][dhf_pkg::SUM_W-1]};
      if (trial >= {1'b0, dvs}) begin
        qbit[ch]     = 1'b1;
        rem_next[ch] = dhf_pkg::CNT_W'(trial - {1'b0, dvs});
      end else begin
        qbit[ch]     = 1'b0;
        rem_next[ch] = dhf_pkg::CNT_W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= busy && (step_cnt == STEP_W'(1));
      if (req.start) begin
        busy     <= 1'b1;
        step_cnt <= STEP_W'(dhf_pkg::SUM_W);
      end else if (busy) begin
        step_cnt <= step_cnt - 1'b1;
        if (step_cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= req.divisor;
      dvd <= req.dividend;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      for (int ch = 0; ch < 3; ch++) begin
        dvd[ch] <= {dvd[ch][dhf_pkg::SUM_W-2:0], 1'b0};
        rem[ch] <= rem_next[ch];
        quo[ch] <= {quo[ch][dhf_pkg::SUM_W-2:0], qbit[ch]};
      end
    end
  end

  always_comb begin
    rsp.done = done;
    for (int ch = 0; ch < 3; ch++) begin
      rsp.quotient[ch] = quo[ch][dhf_pkg::CH_W-1:0];
    end
  end

  `DHF_ASSERT_NXT(a_start_busy, req.start, busy, "divider did not start")

endmodule

FILE: sv/despeckle_hole_fill_filter.sv
// ----------------------------------------------------------------------------
// Despeckle hole fill filter
// 3x3 neighborhood average fill of black pixels, in place, raster order.
// ----------------------------------------------------------------------------
// Usage:
//   pixels   : raster-order RGB pixels (cmd = pixel) or drain items (cmd = drain).
//   filtered : filtered pixels in the same order, delayed by width+1 pixels;
//              frame_end marks the last pixel of a frame.
//   cfg      : register writes (0 level, 1 width, 2 height); any valid index
//              restarts the frame. Write only while the block is idle.
// Items are handled one at a time; ready is high only while idle. A filled
// pixel reads its eight neighbors through the single line RAM read port,
// then goes through an 11-step divide shared by the three channels.
// A result sits in an output register; the next item is taken while it waits,
// and only the write-back of the following result stalls on a busy receiver.
// Reset (rst, synchronous) clears counters and registers; line RAM content is
// not cleared, since a frame only reads entries it has written.
// After each frame, width+1 drain items push out the pending pixels.
// ----------------------------------------------------------------------------
`include "despeckle_hole_fill_filter_assert.svh"

module despeckle_hole_fill_filter (
  input logic      clk,
  input logic      rst,
  dhf_cfg_if.sink  cfg,
  dhf_pix_if.sink  pixels,
  dhf_res_if.source filtered
);

  localparam int COL_W  = dhf_pkg::COL_W;
  localparam int ROW_W  = dhf_pkg::ROW_W;
  localparam int WCNT_W = dhf_pkg::WCNT_W;
  localparam int HCNT_W = dhf_pkg::HCNT_W;
  localparam int BANK_W = dhf_pkg::BANK_W;
  localparam int PIX_W  = dhf_pkg::PIX_W;
  localparam int CH_W   = dhf_pkg::CH_W;
  localparam int SUM_W  = dhf_pkg::SUM_W;
  localparam int CNT_W  = dhf_pkg::CNT_W;
  localparam int SLOT_W = dhf_pkg::SLOT_W;
  localparam int AW     = dhf_pkg::RAM_AW;

  // configuration
  logic [dhf_pkg::LEVEL_W-1:0]      cfg_level;
  logic [dhf_pkg::WIDTH_REG_W-1:0]  cfg_width;
  logic [dhf_pkg::HEIGHT_REG_W-1:0] cfg_height;
  logic [dhf_pkg::LEVEL_W-1:0]      eff_level;
  logic [WCNT_W-1:0]                eff_w;
  logic [HCNT_W-1:0]                eff_h;
  logic                             cfg_wr;
  logic                             cfg_hit;

  // position counters
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [BANK_W-1:0] in_bank;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [BANK_W-1:0] out_bank;
  logic              frame_received;

  logic [WCNT_W-1:0] in_col_inc;
  logic [HCNT_W-1:0] in_row_inc;
  logic [WCNT_W-1:0] out_col_inc;
  logic [HCNT_W-1:0] out_row_inc;
  logic              out_wrap;
  logic              out_last;
  logic              emit_due;

  // item state
  dhf_pkg::state_t           state;
  dhf_pkg::state_t           state_next;
  logic [PIX_W-1:0]          item_px;
  logic                      item_has_in;
  logic                      item_emit;
  logic                      nb_up;
  logic                      nb_down;
  logic                      nb_left;
  logic                      nb_right;
  logic [PIX_W-1:0]          res_px;
  logic [2:0][SUM_W-1:0]     sum;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          blacks;
  logic [SLOT_W-1:0]         slot;
  logic                      pend_valid;
  logic                      pend_ovr;
  logic [PIX_W-1:0]          nbr_px;

  // slot decode
  logic              slot_up;
  logic              slot_down;
  logic              slot_left;
  logic              slot_right;
  logic              slot_center;
  logic              slot_ok;
  logic [BANK_W-1:0] slot_bank;
  logic [COL_W-1:0]  slot_col;

  // output register
  logic             out_valid;
  logic [PIX_W-1:0] out_px;
  logic             out_end;

  // FSM outputs
  logic             pix_take;
  logic             load_out;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [PIX_W-1:0] ram_rdata;
  logic [AW-1:0]    self_addr;
  logic [AW-1:0]    in_addr;
  logic             fill_blocked;

  dhf_pkg::div_req_t div_req;
  dhf_pkg::div_rsp_t div_rsp;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign cfg_hit   = cfg_wr && (cfg.index == dhf_pkg::REG_LEVEL ||
                                cfg.index == dhf_pkg::REG_WIDTH ||
                                cfg.index == dhf_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_level  <= '0;
      cfg_width  <= dhf_pkg::WIDTH_REG_W'(16);
      cfg_height <= dhf_pkg::HEIGHT_REG_W'(16);
    end else if (cfg_wr) begin
      case (cfg.index)
        dhf_pkg::REG_LEVEL:  cfg_level  <= cfg.data[dhf_pkg::LEVEL_W-1:0];
        dhf_pkg::REG_WIDTH:  cfg_width  <= cfg.data[dhf_pkg::WIDTH_REG_W-1:0];
        dhf_pkg::REG_HEIGHT: cfg_height <= cfg.data[dhf_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_level = (cfg_level > dhf_pkg::LEVEL_W'(dhf_pkg::MAX_LEVEL)) ?
                     dhf_pkg::LEVEL_W'(dhf_pkg::MAX_LEVEL) : cfg_level;
  assign eff_w = (cfg_width == '0) ? WCNT_W'(1) :
                 (32'(cfg_width) > 32'(dhf_pkg::MAX_WIDTH)) ?
                 WCNT_W'(dhf_pkg::MAX_WIDTH) : WCNT_W'(cfg_width);
  assign eff_h = (cfg_height == '0) ? HCNT_W'(1) :
                 (32'(cfg_height) > 32'(dhf_pkg::MAX_HEIGHT)) ?
                 HCNT_W'(dhf_pkg::MAX_HEIGHT) : HCNT_W'(cfg_height);

  assign in_col_inc  = WCNT_W'({1'b0, in_col}) + 1'b1;
  assign in_row_inc  = {1'b0, in_row} + 1'b1;
  assign out_col_inc = WCNT_W'({1'b0, out_col}) + 1'b1;
  assign out_row_inc = {1'b0, out_row} + 1'b1;
  assign out_wrap    = out_col_inc >= eff_w;
  assign out_last    = out_wrap && (out_row_inc >= eff_h);
  // input index reached width+1
  assign emit_due    = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);

  assign self_addr = dhf_pkg::ram_addr(out_bank, out_col);
  assign in_addr   = dhf_pkg::ram_addr(in_bank, in_col);

  // neighbor slots in raster order, center skipped
  always_comb begin
    slot_up     = 1'b0;
    slot_down   = 1'b0;
    slot_left   = 1'b0;
    slot_right  = 1'b0;
    slot_center = 1'b0;
    case (slot)
      SLOT_W'(0): begin slot_up = 1'b1;   slot_left = 1'b1;  end
      SLOT_W'(1): begin slot_up = 1'b1;                      end
      SLOT_W'(2): begin slot_up = 1'b1;   slot_right = 1'b1; end
      SLOT_W'(3): begin slot_left = 1'b1;                    end
      SLOT_W'(4): begin slot_center = 1'b1;                  end
      SLOT_W'(5): begin slot_right = 1'b1;                   end
      SLOT_W'(6): begin slot_down = 1'b1; slot_left = 1'b1;  end
      SLOT_W'(7): begin slot_down = 1'b1;                    end
      SLOT_W'(8): begin slot_down = 1'b1; slot_right = 1'b1; end
      default:    begin slot_center = 1'b1;                  end
    endcase
  end

  assign slot_ok = !slot_center && (!slot_up || nb_up) && (!slot_down || nb_down) &&
                   (!slot_left || nb_left) && (!slot_right || nb_right);
  assign slot_bank = slot_up   ? dhf_pkg::bank_dec(out_bank) :
                     slot_down ? dhf_pkg::bank_inc(out_bank) : out_bank;
  assign slot_col  = slot_left  ? out_col - 1'b1 :
                     slot_right ? out_col + 1'b1 : out_col;

  // the lower-right neighbor is the pixel being accepted, not yet in RAM
  assign nbr_px = pend_ovr ? item_px : ram_rdata;
  assign fill_blocked = (blacks >= eff_level) || (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    pix_take      = 1'b0;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = self_addr;
    ram_wdata     = res_px;
    ram_raddr     = self_addr;
    div_req.start = 1'b0;
    case (state)
      dhf_pkg::ST_IDLE: begin
        pix_take = 1'b1;
        if (pixels.valid) begin
          if (pixels.cmd == dhf_pkg::CMD_DRAIN) begin
            if (frame_received) begin
              state_next = dhf_pkg::ST_SELF_RD;
            end
          end else if (!frame_received) begin
            state_next = emit_due ? dhf_pkg::ST_SELF_RD : dhf_pkg::ST_WR_IN;
          end
        end
      end
      dhf_pkg::ST_SELF_RD: begin
        state_next = dhf_pkg::ST_SELF_CHK;
      end
      dhf_pkg::ST_SELF_CHK: begin
        if (eff_level == '0 || ram_rdata != '0) begin
          state_next = dhf_pkg::ST_WR_RES;
        end else begin
          state_next = dhf_pkg::ST_NBR;
        end
      end
      dhf_pkg::ST_NBR: begin
        ram_raddr = dhf_pkg::ram_addr(slot_bank, slot_col);
        if (slot == SLOT_W'(dhf_pkg::NBR_SLOTS)) begin
          state_next = dhf_pkg::ST_DIV_GO;
        end
      end
      dhf_pkg::ST_DIV_GO: begin
        if (fill_blocked) begin
          state_next = dhf_pkg::ST_WR_RES;
        end else begin
          div_req.start = 1'b1;
          state_next    = dhf_pkg::ST_DIV_WAIT;
        end
      end
      dhf_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = dhf_pkg::ST_WR_RES;
        end
      end
      dhf_pkg::ST_WR_RES: begin
        if (!out_valid || filtered.ready) begin
          ram_we     = 1'b1;
          load_out   = 1'b1;
          state_next = item_has_in ? dhf_pkg::ST_WR_IN : dhf_pkg::ST_UPD;
        end
      end
      dhf_pkg::ST_WR_IN: begin
        ram_we     = 1'b1;
        ram_waddr  = in_addr;
        ram_wdata  = item_px;
        state_next = dhf_pkg::ST_UPD;
      end
      dhf_pkg::ST_UPD: begin
        state_next = dhf_pkg::ST_IDLE;
      end
      default: begin
        state_next = dhf_pkg::ST_IDLE;
      end
    endcase
  end

  assign pixels.ready    = pix_take;
  assign div_req.divisor = cnt;
  assign div_req.dividend = sum;

  // item datapath
  always_ff @(posedge clk) begin
    if (state == dhf_pkg::ST_IDLE && pixels.valid) begin
      item_px     <= {pixels.pixel_red, pixels.pixel_green, pixels.pixel_blue};
      item_has_in <= (pixels.cmd == dhf_pkg::CMD_PIXEL);
      item_emit   <= (pixels.cmd == dhf_pkg::CMD_DRAIN) || emit_due;
      nb_up       <= out_row != '0;
      nb_down     <= out_row_inc < eff_h;
      nb_left     <= out_col != '0;
      nb_right    <= out_col_inc < eff_w;
    end
    case (state)
      dhf_pkg::ST_SELF_CHK: begin
        res_px     <= ram_rdata;
        sum        <= '0;
        cnt        <= '0;
        blacks     <= '0;
        slot       <= '0;
        pend_valid <= 1'b0;
        pend_ovr   <= 1'b0;
      end
      dhf_pkg::ST_NBR: begin
        if (slot != SLOT_W'(dhf_pkg::NBR_SLOTS)) begin
          pend_valid <= slot_ok;
          pend_ovr   <= slot_down && slot_right && item_has_in;
          slot       <= slot + 1'b1;
        end else begin
          pend_valid <= 1'b0;
        end
        if (pend_valid) begin
          cnt <= cnt + 1'b1;
          if (nbr_px == '0) begin
            blacks <= blacks + 1'b1;
          end
          for (int ch = 0; ch < 3; ch++) begin
            sum[ch] <= sum[ch] + SUM_W'(nbr_px[ch*CH_W +: CH_W]);
          end
        end
      end
      dhf_pkg::ST_DIV_GO: begin
        if (fill_blocked) begin
          res_px <= '0;
        end
      end
      dhf_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_px <= div_rsp.quotient;
        end
      end
      default: ;
    endcase
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_col         <= '0;
      in_row         <= '0;
      in_bank        <= '0;
      out_col        <= '0;
      out_row        <= '0;
      out_bank       <= '0;
      frame_received <= 1'b0;
    end else if (state == dhf_pkg::ST_UPD) begin
      if (item_emit && out_last) begin
        in_col         <= '0;
        in_row         <= '0;
        in_bank        <= '0;
        out_col        <= '0;
        out_row        <= '0;
        out_bank       <= '0;
        frame_received <= 1'b0;
      end else begin
        if (item_emit) begin
          if (out_wrap) begin
            out_col  <= '0;
            out_row  <= out_row + 1'b1;
            out_bank <= dhf_pkg::bank_inc(out_bank);
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
        if (item_has_in) begin
          if (in_col_inc >= eff_w) begin
            in_col <= '0;
            if (in_row_inc >= eff_h) begin
              in_row         <= '0;
              in_bank        <= '0;
              frame_received <= 1'b1;
            end else begin
              in_row  <= in_row + 1'b1;
              in_bank <= dhf_pkg::bank_inc(in_bank);
            end
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_px  <= res_px;
      out_end <= out_last;
    end
  end

  assign filtered.valid     = out_valid;
  assign filtered.out_red   = out_px[2*CH_W +: CH_W];
  assign filtered.out_green = out_px[CH_W +: CH_W];
  assign filtered.out_blue  = out_px[0 +: CH_W];
  assign filtered.frame_end = out_end;

  dhf_line_ram #(
    .DEPTH  (dhf_pkg::RAM_DEPTH),
    .DATA_W (PIX_W),
    .ADDR_W (AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dhf_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `DHF_ASSERT_IMP(a_wr_res_hold, (state == dhf_pkg::ST_WR_RES) && out_valid && !filtered.ready, !ram_we, "result written back while output register busy")
  `DHF_ASSERT_IMP(a_div_done_wait, div_rsp.done, state == dhf_pkg::ST_DIV_WAIT, "divider done outside wait state")
  `DHF_ASSERT_NXT(a_pixel_ignored, (state == dhf_pkg::ST_IDLE) && pixels.valid && (pixels.cmd == dhf_pkg::CMD_PIXEL) && frame_received, state == dhf_pkg::ST_IDLE, "pixel after full frame not ignored")

endmodule
